### rtl/lzbsd_pkg.sv
// lzbsd_pkg: types, codes and constants for the block stream decoder
// used by every module under rtl
package lzbsd_pkg;
  localparam int WindowDepthDefault = 2048;
  localparam int MinMatchDefault    = 3;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_OFFSET    = 3'd1;
  localparam logic [2:0] ERR_CAPACITY  = 3'd2;
  localparam logic [2:0] ERR_TRUNC_TOK = 3'd3;
  localparam logic [2:0] ERR_LENGTH    = 3'd4;
  localparam logic [2:0] ERR_TRUNC_BLK = 3'd5;

  localparam logic [7:0] TAG_MATCH_BIT = 8'h80;
  localparam logic [3:0] LEN_MASK      = 4'h0F;
  localparam logic [2:0] OFF_MASK      = 3'h07;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  kind;
    logic [2:0]  error_code;
    logic [23:0] total_length;
    logic        run_end;
  } out_beat_t;

  // decoder phase (one-hot)
  typedef enum logic [9:0] {
    PH_HDR0   = 10'b0000000001,
    PH_HDR1   = 10'b0000000010,
    PH_HDR2   = 10'b0000000100,
    PH_HDR3   = 10'b0000001000,
    PH_TAG    = 10'b0000010000,
    PH_LIT    = 10'b0000100000,
    PH_MLO    = 10'b0001000000,
    PH_STORED = 10'b0010000000,
    PH_SKIP   = 10'b0100000000,
    PH_ERR    = 10'b1000000000
  } phase_t;

  // controller sequencer state (one-hot)
  typedef enum logic [3:0] {
    CS_IDLE  = 4'b0001,
    CS_COPY  = 4'b0010,
    CS_TAIL  = 4'b0100,
    CS_WAIT  = 4'b1000
  } ctl_state_t;

  // datapath to controller status
  typedef struct packed {
    logic [7:0] rd_byte;   // history read data
  } dp_status_t;

  // controller to datapath commands
  typedef struct packed {
    logic        rd_en;
    logic [15:0] rd_addr;
    logic        wr_en;
    logic [15:0] wr_addr;
    logic [7:0]  wr_data;
  } dp_cmd_t;
endpackage

### rtl/lz_block_stream_decoder_core.sv
// block lz stream decoder: top level with register port
// depends on lzbsd_pkg, lzbsd_ctrl, lzbsd_history
// timing: a stored or literal byte, or a lone done or error result, is valid the cycle
//   after its input is accepted; a match byte passes the history read and output registers
// throughput: one beat per cycle for headers and literals while the output is not stalled;
//   a match holds the input while the history read after write copies it, and a result that
//   closes a data byte or match holds the input until that result is sent
// reset: synchronous rst returns to awaiting a header; history is not cleared
module lz_block_stream_decoder_core #(
  parameter int WINDOW_DEPTH     = lzbsd_pkg::WindowDepthDefault,
  parameter int MIN_MATCH_LENGTH = lzbsd_pkg::MinMatchDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lzbsd_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lzbsd_pkg::out_beat_t out_data
);
  localparam logic [1:0] REG_CAPACITY = 2'd0;

  logic [23:0] capacity;
  lzbsd_pkg::dp_cmd_t    cmd;
  lzbsd_pkg::dp_status_t status;

  assign pready = 1'b1;
  // capacity register at byte address zero
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= 24'hFFFFFF;
    end else if (psel && penable && pwrite && paddr == REG_CAPACITY) begin
      capacity <= pwdata[23:0];
    end
  end
  assign prdata = (paddr == REG_CAPACITY) ? {8'd0, capacity} : 32'd0;

  lzbsd_ctrl #(.WINDOW_DEPTH(WINDOW_DEPTH), .MIN_MATCH_LENGTH(MIN_MATCH_LENGTH)) u_ctrl (
    .clk, .rst, .capacity, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .cmd, .status
  );

  lzbsd_history #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_hist (
    .clk, .cmd, .status
  );
endmodule

### rtl/lzbsd_history.sv
// lzbsd_history: block-local history memory, one write and one read port
// depends on lzbsd_pkg
module lzbsd_history #(
  parameter int WINDOW_DEPTH = lzbsd_pkg::WindowDepthDefault
) (
  input  logic                   clk,
  input  lzbsd_pkg::dp_cmd_t     cmd,
  output lzbsd_pkg::dp_status_t  status
);
  localparam int AW = $clog2(WINDOW_DEPTH);
  logic [7:0] mem [WINDOW_DEPTH];
  logic [7:0] rd_q;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr[AW-1:0]] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      rd_q <= mem[cmd.rd_addr[AW-1:0]];
    end
  end

  assign status.rd_byte = rd_q;
endmodule

### rtl/lzbsd_ctrl.sv
// lzbsd_ctrl: token parser, header checks and match copy sequencer
// depends on lzbsd_pkg; drives lzbsd_history through dp_cmd_t
module lzbsd_ctrl #(
  parameter int WINDOW_DEPTH     = lzbsd_pkg::WindowDepthDefault,
  parameter int MIN_MATCH_LENGTH = lzbsd_pkg::MinMatchDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [23:0]           capacity,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  lzbsd_pkg::in_beat_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lzbsd_pkg::out_beat_t  out_data,
  output lzbsd_pkg::dp_cmd_t    cmd,
  input  lzbsd_pkg::dp_status_t status
);
  localparam logic [16:0] WinLim = 17'(WINDOW_DEPTH);

  lzbsd_pkg::phase_t     phase;
  lzbsd_pkg::ctl_state_t cs;
  logic [15:0] raw_len, enc_len, consumed, outcnt;
  logic [6:0]  lit_rem;
  logic [7:0]  ptag;
  logic [23:0] scount;
  // copy bookkeeping
  logic [4:0]  copy_rem;
  logic [15:0] src;
  logic        rd_pend;
  // tail result after a copy
  logic        tail_v;
  logic [1:0]  tail_kind;
  logic [2:0]  tail_err;
  logic        tail_last;
  logic        out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (cs != lzbsd_pkg::CS_IDLE) || !out_free;
  logic acc;
  assign acc = in_valid && !in_stall;

  // combinational decode of one accepted byte
  logic [7:0]  b;
  logic        last;
  logic [15:0] cons1;
  logic        emit;     // data byte goes out
  logic        do_copy;
  logic [2:0]  err;
  logic [4:0]  mlen;
  logic [10:0] moff;
  lzbsd_pkg::phase_t ph_n;
  logic [16:0] sum_c, sum_o;
  logic        fin_err;
  logic [24:0] capsum;

  assign b     = in_data.in_byte;
  assign last  = in_data.in_last;
  assign cons1 = consumed + 16'd1;
  assign mlen  = 5'((ptag[6:3] & lzbsd_pkg::LEN_MASK)) + 5'(MIN_MATCH_LENGTH);
  assign moff  = {ptag[2:0] & lzbsd_pkg::OFF_MASK, b};
  assign sum_c = {1'b0, cons1} + 17'(b);
  assign sum_o = {1'b0, outcnt} + 17'(b[6:0]);
  assign capsum = {1'b0, scount} + 25'(raw_len);

  always_comb begin
    emit = 1'b0; do_copy = 1'b0; err = lzbsd_pkg::ERR_NONE; ph_n = phase;
    fin_err = 1'b0;
    unique case (phase)
      lzbsd_pkg::PH_ERR:  ph_n = phase;
      lzbsd_pkg::PH_HDR0: ph_n = lzbsd_pkg::PH_HDR1;
      lzbsd_pkg::PH_HDR1: ph_n = lzbsd_pkg::PH_HDR2;
      lzbsd_pkg::PH_HDR2: ph_n = lzbsd_pkg::PH_HDR3;
      lzbsd_pkg::PH_HDR3: begin
        if (capsum > {1'b0, capacity}) err = lzbsd_pkg::ERR_CAPACITY;
        else if ({b, enc_len[7:0]} == 16'd0 && raw_len != 16'd0)
          err = lzbsd_pkg::ERR_LENGTH;
        if ({b, enc_len[7:0]} == 16'd0) ph_n = lzbsd_pkg::PH_HDR0;
        else if (raw_len == {b, enc_len[7:0]}) ph_n = lzbsd_pkg::PH_STORED;
        else ph_n = lzbsd_pkg::PH_TAG;
      end
      lzbsd_pkg::PH_STORED: begin
        emit = 1'b1;
        if (cons1 >= enc_len) ph_n = lzbsd_pkg::PH_HDR0;
      end
      lzbsd_pkg::PH_TAG: begin
        if (b == 8'd0) begin
          ph_n = lzbsd_pkg::PH_SKIP;
          fin_err = cons1 >= enc_len;
        end else if ((b & lzbsd_pkg::TAG_MATCH_BIT) != 8'd0) begin
          if (cons1 >= enc_len) err = lzbsd_pkg::ERR_TRUNC_TOK;
          else ph_n = lzbsd_pkg::PH_MLO;
        end else if (sum_c > {1'b0, enc_len}) err = lzbsd_pkg::ERR_TRUNC_TOK;
        else if (sum_o > {1'b0, raw_len}) err = lzbsd_pkg::ERR_LENGTH;
        else ph_n = lzbsd_pkg::PH_LIT;
      end
      lzbsd_pkg::PH_LIT: begin
        emit = 1'b1;
        if (lit_rem == 7'd1) begin
          ph_n = lzbsd_pkg::PH_TAG;
          fin_err = cons1 >= enc_len;
        end
      end
      lzbsd_pkg::PH_MLO: begin
        if (moff == 11'd0 || {5'd0, moff} > outcnt || 17'(moff) > WinLim)
          err = lzbsd_pkg::ERR_OFFSET;
        else if (({1'b0, outcnt} + 17'(mlen)) > {1'b0, raw_len})
          err = lzbsd_pkg::ERR_LENGTH;
        else begin
          do_copy = 1'b1;
          ph_n = lzbsd_pkg::PH_TAG;
          fin_err = cons1 >= enc_len;
        end
      end
      lzbsd_pkg::PH_SKIP: fin_err = cons1 >= enc_len;
      default: ph_n = lzbsd_pkg::PH_ERR;
    endcase
  end

  // block finish: output count after this byte must equal raw length
  logic [15:0] outcnt_after;
  logic        fin_bad;
  assign outcnt_after = outcnt + (emit ? 16'd1 : 16'd0) + (do_copy ? 16'(mlen) : 16'd0);
  assign fin_bad = fin_err && (outcnt_after != raw_len);

  // result that closes this byte, if any
  logic        t_v;
  logic [1:0]  t_kind;
  logic [2:0]  t_err;
  lzbsd_pkg::phase_t ph_f;
  always_comb begin
    t_v = 1'b0; t_kind = lzbsd_pkg::KIND_DONE; t_err = lzbsd_pkg::ERR_NONE;
    ph_f = ph_n;
    if (fin_err && !fin_bad) ph_f = lzbsd_pkg::PH_HDR0;
    if (err != lzbsd_pkg::ERR_NONE || fin_bad) begin
      t_v = 1'b1; t_kind = lzbsd_pkg::KIND_ERROR;
      t_err = fin_bad ? lzbsd_pkg::ERR_LENGTH : err;
      ph_f = lzbsd_pkg::PH_ERR;
    end else if (last) begin
      t_v = 1'b1;
      if (ph_f == lzbsd_pkg::PH_HDR0 || ph_f == lzbsd_pkg::PH_HDR1 ||
          ph_f == lzbsd_pkg::PH_HDR2 || ph_f == lzbsd_pkg::PH_HDR3) begin
        t_kind = lzbsd_pkg::KIND_DONE;
      end else begin
        t_kind = lzbsd_pkg::KIND_ERROR; t_err = lzbsd_pkg::ERR_TRUNC_BLK;
      end
    end
    if (last) ph_f = lzbsd_pkg::PH_HDR0;
  end

  // output register loads a new beat
  logic load_out;
  assign load_out =
    (cs == lzbsd_pkg::CS_IDLE && acc && phase != lzbsd_pkg::PH_ERR &&
     (emit || (!do_copy && t_v))) ||
    (cs == lzbsd_pkg::CS_COPY && rd_pend && out_free) ||
    (cs == lzbsd_pkg::CS_TAIL && out_free);

  // history commands: write on every data byte, read during a copy
  logic [15:0] rd_addr_c;
  assign rd_addr_c = (cs == lzbsd_pkg::CS_IDLE) ? (outcnt - {5'd0, moff}) : src;
  always_comb begin
    cmd.wr_en   = 1'b0;
    cmd.wr_addr = outcnt;
    cmd.wr_data = b;
    cmd.rd_en   = 1'b0;
    cmd.rd_addr = rd_addr_c;
    if (acc && phase != lzbsd_pkg::PH_ERR && emit) cmd.wr_en = 1'b1;
    if (acc && phase != lzbsd_pkg::PH_ERR && do_copy) cmd.rd_en = 1'b1;
    if (cs == lzbsd_pkg::CS_COPY && rd_pend && out_free) begin
      cmd.wr_en = 1'b1; cmd.wr_data = status.rd_byte;
    end
    // read in the cycle after the write so overlapping copies see new bytes
    if (cs == lzbsd_pkg::CS_COPY && !rd_pend) cmd.rd_en = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= lzbsd_pkg::PH_HDR0; cs <= lzbsd_pkg::CS_IDLE;
      raw_len <= '0; enc_len <= '0; consumed <= '0; outcnt <= '0;
      lit_rem <= '0; ptag <= '0; scount <= '0; out_valid <= 1'b0;
      copy_rem <= '0; src <= '0; rd_pend <= 1'b0; tail_v <= 1'b0;
      tail_kind <= '0; tail_err <= '0; tail_last <= 1'b0;
    end else begin
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (cs)
        lzbsd_pkg::CS_IDLE: begin
          if (acc) begin
            if (phase == lzbsd_pkg::PH_ERR) begin
              if (last) begin phase <= lzbsd_pkg::PH_HDR0; scount <= '0; end
            end else begin
              phase <= ph_f;
              if (phase != lzbsd_pkg::PH_HDR0 && phase != lzbsd_pkg::PH_HDR1 &&
                  phase != lzbsd_pkg::PH_HDR2 && phase != lzbsd_pkg::PH_HDR3)
                consumed <= cons1;
              if (phase == lzbsd_pkg::PH_HDR0) raw_len <= {8'd0, b};
              if (phase == lzbsd_pkg::PH_HDR1) raw_len[15:8] <= b;
              if (phase == lzbsd_pkg::PH_HDR2) enc_len <= {8'd0, b};
              if (phase == lzbsd_pkg::PH_HDR3) begin
                enc_len[15:8] <= b; consumed <= '0; outcnt <= '0; lit_rem <= '0;
              end
              if (phase == lzbsd_pkg::PH_TAG) begin
                ptag <= b; lit_rem <= b[6:0];
              end
              if (phase == lzbsd_pkg::PH_LIT) lit_rem <= lit_rem - 7'd1;
              if (emit) begin
                outcnt <= outcnt + 16'd1;
                scount <= scount + 24'd1;
                out_data <= '{out_byte: b, kind: lzbsd_pkg::KIND_DATA,
                              error_code: lzbsd_pkg::ERR_NONE,
                              total_length: scount + 24'd1, run_end: !t_v};
                if (t_v) begin
                  cs <= lzbsd_pkg::CS_TAIL; tail_kind <= t_kind; tail_err <= t_err;
                  tail_last <= last;
                end
              end else if (do_copy) begin
                cs <= lzbsd_pkg::CS_COPY; copy_rem <= mlen;
                src <= outcnt - {5'd0, moff} + 16'd1; rd_pend <= 1'b1;
                tail_v <= t_v; tail_kind <= t_kind; tail_err <= t_err;
                tail_last <= last;
              end else if (t_v) begin
                out_data <= '{out_byte: 8'd0, kind: t_kind, error_code: t_err,
                              total_length: scount, run_end: 1'b1};
                if (last) scount <= '0;
              end
            end
          end
        end
        lzbsd_pkg::CS_COPY: begin
          if (rd_pend && out_free) begin
            out_data <= '{out_byte: status.rd_byte, kind: lzbsd_pkg::KIND_DATA,
                          error_code: lzbsd_pkg::ERR_NONE,
                          total_length: scount + 24'd1,
                          run_end: copy_rem == 5'd1 && !tail_v};
            outcnt <= outcnt + 16'd1; scount <= scount + 24'd1;
            copy_rem <= copy_rem - 5'd1;
            // write then read next cycle so overlapping copies see new bytes
            rd_pend <= 1'b0;
            if (copy_rem == 5'd1) cs <= tail_v ? lzbsd_pkg::CS_TAIL : lzbsd_pkg::CS_IDLE;
          end else if (!rd_pend) begin
            src <= src + 16'd1;
            rd_pend <= 1'b1;
          end
        end
        lzbsd_pkg::CS_TAIL: begin
          if (out_free) begin
            out_data <= '{out_byte: 8'd0, kind: tail_kind, error_code: tail_err,
                          total_length: scount, run_end: 1'b1};
            if (tail_last) scount <= '0;
            tail_v <= 1'b0;
            cs <= lzbsd_pkg::CS_IDLE;
          end
        end
        lzbsd_pkg::CS_WAIT: cs <= lzbsd_pkg::CS_IDLE;
        default: cs <= lzbsd_pkg::CS_IDLE;
      endcase
    end
  end
endmodule
